@@ sv/oversampled_ir_packet_receiver_macros.svh @@
// Assertion macros used by the IR receiver checker.
// No dependencies; included by the checker file.
`ifndef OVERSAMPLED_IR_PACKET_RECEIVER_MACROS_SVH
`define OVERSAMPLED_IR_PACKET_RECEIVER_MACROS_SVH

// clocked assertion, disabled while reset is high
`define OPIR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define OPIR_ASSERT_NORST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/opir_pkg.sv @@
// Shared types and constants of the oversampled IR packet receiver.
// No dependencies; imported by every module of the block except opir_ram.
package opir_pkg;

  typedef logic signed [5:0] tick_t;
  typedef logic signed [8:0] bias_t;
  typedef logic [0:0]        reg_idx_t;

  // configuration register indexes
  localparam reg_idx_t REG_START_CODE = 1'b0;
  localparam reg_idx_t REG_ZERO_LIMIT = 1'b1;

  localparam logic [3:0] START_CODE_RST = 4'd12;
  localparam logic [3:0] ZERO_LIMIT_RST = 4'd10;

  // bit timing
  localparam tick_t BIT_TICKS  = 6'sd30;
  localparam tick_t MID_TICK   = 6'sd16;
  localparam tick_t MID_LESS1  = 6'sd15;
  localparam tick_t EARLY_EDGE = 6'sd4;
  localparam tick_t LATE_EDGE  = 6'sd27;
  localparam tick_t TICK_IDLE  = 6'sd1;
  localparam tick_t TICK_SHIFT = 6'sd2;
  localparam bias_t BIAS_IDLE   = 9'sd15;
  localparam bias_t LATE_BIAS   = 9'sd28;
  localparam bias_t STRONG_BIAS = 9'sd100;
  localparam logic [3:0] HITS_MAX   = 4'd15;
  localparam logic [4:0] START_HITS = 5'd4;

  // start nibble halves
  localparam logic [3:0] START_HI = 4'hC;
  localparam logic [3:0] START_LO = 4'h3;

  localparam logic [7:0] SUM_BASE = 8'hFF;

  // look directions, in priority order
  localparam logic [1:0] DIR_FRONT = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_GOOD      = 2'd0;
  localparam logic [1:0] STATUS_BAD_START = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM   = 2'd2;

  // decoder to packet buffer events
  typedef struct packed {
    logic       byte_done;  // a full byte was decoded
    logic       pkt_done;   // that byte closes the packet
    logic       restart;    // decoder went back to idle
    logic       bad;        // start nibble did not match
    logic [7:0] data;
  } opir_byte_ev_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_SHOW
  } opir_emit_state_t;

endpackage

@@ sv/opir_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module opir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/opir_bit_timer.sv @@
// Sample-tick decoder: direction pick, Manchester bit timing, start nibble, bytes.
// Depends on opir_pkg; feeds opir_packet_buf with byte events.
module opir_bit_timer
  import opir_pkg::*;
#(
  parameter int PACKET_BYTES = 8,
  parameter int AW = $clog2(PACKET_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [3:0]    pins,
  input  logic          cfg_we,
  input  reg_idx_t      cfg_index,
  input  logic [3:0]    cfg_data,
  output opir_byte_ev_t ev,
  output logic [AW-1:0] byte_addr
);

  localparam int BW = $clog2(PACKET_BYTES + 1);
  localparam logic [BW-1:0] LAST_BYTE = BW'(PACKET_BYTES - 1);

  logic [3:0] start_code, zero_limit;

  logic          sampling, sampling_next;
  logic [1:0]    look_dir, look_dir_next;
  logic [1:0]    phase, phase_next;
  logic [3:0]    start_bits, start_bits_next;
  logic          start_bad, start_bad_next;
  logic [2:0]    bitpos, bitpos_next;
  logic [BW-1:0] bytes_done, bytes_done_next;
  tick_t         tick, tick_next;
  bias_t         bias, bias_next;
  logic [3:0]    early, early_next;
  logic [3:0]    late, late_next;
  logic [3:0]    zbits, zbits_next;
  logic [6:0]    acc, acc_next;

  logic [3:0] active;
  logic       hit, sample, go_idle, mid_bias;
  tick_t      tick_n, delta;
  bias_t      bias_a;
  logic [3:0] early_a, late_a, z_inc;
  logic [3:0] nibble;

  assign active    = ~pins;
  assign byte_addr = bytes_done[AW-1:0];

  always_comb begin
    unique case (look_dir)
      DIR_FRONT: hit = active[3];
      DIR_BACK:  hit = active[2];
      DIR_RIGHT: hit = active[1];
      default:   hit = active[0];
    endcase
  end

  // per-tick bias and drift counters
  always_comb begin
    tick_n   = tick + TICK_IDLE;
    delta    = (tick_n < MID_TICK) ? MID_TICK - tick_n : MID_LESS1 - tick_n;
    bias_a   = hit ? bias + 9'(delta) : bias;
    early_a  = (hit && tick_n < EARLY_EDGE && early < HITS_MAX) ? early + 4'd1 : early;
    late_a   = (hit && tick_n > LATE_EDGE && late < HITS_MAX) ? late + 4'd1 : late;
    mid_bias = (bias_a < STRONG_BIAS) && (bias_a > -STRONG_BIAS);
    z_inc    = (bias_a == '0 && zbits < HITS_MAX) ? zbits + 4'd1 : zbits;
  end

  always_comb begin
    sampling_next   = sampling;
    look_dir_next   = look_dir;
    phase_next      = phase;
    start_bits_next = start_bits;
    start_bad_next  = start_bad;
    bitpos_next     = bitpos;
    bytes_done_next = bytes_done;
    tick_next       = tick;
    bias_next       = bias;
    early_next      = early;
    late_next       = late;
    zbits_next      = zbits;
    acc_next        = acc;
    ev              = '0;
    ev.bad          = start_bad;
    sample          = 1'b0;
    go_idle         = 1'b0;
    nibble          = start_bits;

    if (accept) begin
      if (!sampling) begin
        sampling_next = |active;
        priority if (active[3]) look_dir_next = DIR_FRONT;
        else if (active[2])     look_dir_next = DIR_BACK;
        else if (active[1])     look_dir_next = DIR_RIGHT;
        else if (active[0])     look_dir_next = DIR_LEFT;
        else                    look_dir_next = look_dir;
      end else begin
        tick_next = tick_n;
        if (tick_n > 6'sd0) begin
          bias_next  = bias_a;
          early_next = early_a;
          late_next  = late_a;
          if (tick_n >= BIT_TICKS) begin
            sample     = ~bias_a[8];
            tick_next  = '0;
            bias_next  = '0;
            early_next = '0;
            late_next  = '0;
            if (phase < 2'd2) begin
              sample = ({1'b0, early_a} + {1'b0, late_a}) > START_HITS;
            end else if (mid_bias) begin
              zbits_next = z_inc;
              if (z_inc > zero_limit) begin
                go_idle = 1'b1;
              end else if (early_a < 4'd2 && late_a < 4'd2) begin
                tick_next = sample ? -TICK_SHIFT : TICK_SHIFT;
              end else if (early_a > 4'd1 && late_a > 4'd1) begin
                tick_next = sample ? TICK_SHIFT : -TICK_SHIFT;
                bias_next = sample ? LATE_BIAS : '0;
              end
            end

            if (!go_idle) begin
              unique case (phase)
                2'd0: begin
                  start_bits_next = sample ? START_HI : '0;
                  phase_next      = 2'd1;
                end
                2'd1: begin
                  nibble          = start_bits | (sample ? START_LO : '0);
                  start_bits_next = nibble;
                  phase_next      = 2'd2;
                  if (nibble == start_code) begin
                    start_bad_next = 1'b0;
                  end else if (nibble == '0) begin
                    go_idle = 1'b1;
                  end else begin
                    start_bad_next = 1'b1;
                  end
                end
                default: begin
                  acc_next = {acc[5:0], sample};
                  if (bitpos == 3'd0) begin
                    ev.byte_done    = 1'b1;
                    ev.data         = {acc, sample};
                    bitpos_next     = 3'd7;
                    bytes_done_next = bytes_done + 1'b1;
                    if (bytes_done == LAST_BYTE) begin
                      ev.pkt_done = 1'b1;
                      go_idle     = 1'b1;
                    end
                  end else begin
                    bitpos_next = bitpos - 3'd1;
                  end
                end
              endcase
            end
          end
        end
      end
    end

    if (go_idle) begin
      ev.restart      = 1'b1;
      sampling_next   = 1'b0;
      phase_next      = '0;
      start_bits_next = '0;
      start_bad_next  = 1'b0;
      bitpos_next     = 3'd7;
      bytes_done_next = '0;
      tick_next       = TICK_IDLE;
      bias_next       = BIAS_IDLE;
      early_next      = 4'd1;
      late_next       = '0;
      zbits_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= START_CODE_RST;
      zero_limit <= ZERO_LIMIT_RST;
      sampling   <= 1'b0;
      look_dir   <= DIR_FRONT;
      phase      <= '0;
      start_bits <= '0;
      start_bad  <= 1'b0;
      bitpos     <= 3'd7;
      bytes_done <= '0;
      tick       <= TICK_IDLE;
      bias       <= BIAS_IDLE;
      early      <= 4'd1;
      late       <= '0;
      zbits      <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_START_CODE) start_code <= cfg_data;
      if (cfg_we && cfg_index == REG_ZERO_LIMIT) zero_limit <= cfg_data;
      sampling   <= sampling_next;
      look_dir   <= look_dir_next;
      phase      <= phase_next;
      start_bits <= start_bits_next;
      start_bad  <= start_bad_next;
      bitpos     <= bitpos_next;
      bytes_done <= bytes_done_next;
      tick       <= tick_next;
      bias       <= bias_next;
      early      <= early_next;
      late       <= late_next;
      zbits      <= zbits_next;
    end
  end

  // partial byte, MSB first
  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

@@ sv/opir_packet_buf.sv @@
// Packet store in RAM, running checksum and result word sequencer.
// Depends on opir_pkg and opir_ram.
module opir_packet_buf
  import opir_pkg::*;
#(
  parameter int PACKET_BYTES = 8,
  parameter int AW = $clog2(PACKET_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  opir_byte_ev_t ev,
  input  logic [AW-1:0] byte_addr,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [4:0]    out_index,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_status,
  output logic          out_last
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(PACKET_BYTES - 1);

  opir_emit_state_t state, state_next;
  logic [AW-1:0] idx;
  logic [7:0]    sum;
  logic [1:0]    status_r;
  logic          bad_r;
  logic          ram_re, load, idx_inc, final_word;
  logic [7:0]    rdata;

  opir_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_ram (
    .clk   (clk),
    .we    (ev.byte_done && !ev.bad),
    .waddr (byte_addr),
    .wdata (ev.data),
    .re    (ram_re),
    .raddr (idx),
    .rdata (rdata)
  );

  assign busy       = (state != EM_IDLE);
  assign final_word = bad_r || (idx == LAST_ADDR);

  always_comb begin
    state_next = state;
    unique case (state)
      EM_IDLE: if (ev.pkt_done) state_next = ev.bad ? EM_SHOW : EM_READ;
      EM_READ: state_next = EM_SHOW;
      EM_SHOW: if (!out_valid || out_ready) state_next = final_word ? EM_IDLE : EM_READ;
      default: state_next = EM_IDLE;
    endcase
  end

  always_comb begin
    ram_re  = 1'b0;
    load    = 1'b0;
    idx_inc = 1'b0;
    unique case (state)
      EM_READ: ram_re = 1'b1;
      EM_SHOW: begin
        load    = !out_valid || out_ready;
        idx_inc = load && !final_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ev.pkt_done || ev.restart) begin
        sum <= '0;
      end else if (ev.byte_done && !ev.bad && byte_addr != LAST_ADDR) begin
        sum <= sum + ev.data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == EM_IDLE && ev.pkt_done) begin
      idx   <= '0;
      bad_r <= ev.bad;
      if (ev.bad) begin
        status_r <= STATUS_BAD_START;
      end else begin
        status_r <= ((SUM_BASE - sum) != ev.data) ? STATUS_BAD_SUM : STATUS_GOOD;
      end
    end else if (idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (load) begin
      out_index  <= bad_r ? 5'd0 : 5'(idx);
      out_byte   <= bad_r ? 8'd0 : rdata;
      out_status <= status_r;
      out_last   <= final_word;
    end
  end

endmodule

@@ sv/oversampled_ir_packet_receiver.sv @@
// Oversampled IR packet receiver, top level.
// Depends on opir_pkg, opir_bit_timer, opir_packet_buf (and through it opir_ram).
//
// Slave stream: one word per IR sample tick, s_tdata[3:0] = pins (active low,
// bit3 front, bit2 back, bit1 right, bit0 left). A word is taken while no packet
// is being streamed out.
// Master stream: one word per received packet byte; m_tlast marks the final
// word of the packet. A bad start nibble gives a single word with status 1.
// Config port: cfg_we writes cfg_data into register cfg_index (0 start code,
// 1 zero-bias limit); write only while no packet is in flight.
// After the tick ending the last bit, m_tvalid rises once the packet buffer has done
// a RAM read and then an output register load (only the load for a bad start).
// Each further byte again takes one RAM read and one output register load, and
// s_tready stays low until the last word of the packet has been loaded.
// A stalled master side holds the output register and freezes the read
// sequencer; sample words are not taken until the last word has been loaded.
// Reset (rst, synchronous) returns the decoder to waiting for pin activity,
// restores the register defaults and drops m_tvalid. The RAM needs no clearing.
module oversampled_ir_packet_receiver
  import opir_pkg::*;
#(
  parameter int PACKET_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] pins, [7:4] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] byte_index, [12:5] data_byte, [14:13] status, [15] zero
  output logic        m_tlast,
  input  logic        cfg_we,
  input  reg_idx_t    cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int AW = $clog2(PACKET_BYTES);

  opir_byte_ev_t ev;
  logic [AW-1:0] byte_addr;
  logic          busy;
  logic [4:0]    out_index;
  logic [7:0]    out_byte;
  logic [1:0]    out_status;

  assign s_tready = !busy;
  assign m_tdata  = {1'b0, out_status, out_byte, out_index};

  opir_bit_timer #(.PACKET_BYTES(PACKET_BYTES), .AW(AW)) u_timer (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_tvalid && s_tready),
    .pins      (s_tdata[3:0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev        (ev),
    .byte_addr (byte_addr)
  );

  opir_packet_buf #(.PACKET_BYTES(PACKET_BYTES), .AW(AW)) u_buf (
    .clk        (clk),
    .rst        (rst),
    .ev         (ev),
    .byte_addr  (byte_addr),
    .busy       (busy),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_index  (out_index),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

endmodule

@@ sv/opir_checker.sv @@
// Port-level checks of the IR packet receiver, bound to the top level.
// Depends on opir_pkg and oversampled_ir_packet_receiver_macros.svh.
`include "oversampled_ir_packet_receiver_macros.svh"

module opir_checker
  import opir_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  `OPIR_ASSERT_NORST(a_rst_drops_valid, clk, rst |=> !m_tvalid, "m_tvalid set after reset")

  `OPIR_ASSERT(a_hold_stalled, clk, rst, (m_tvalid && !m_tready) |=> $stable(m_tdata) && m_tvalid, "stalled word changed")

  `OPIR_ASSERT(a_status_code, clk, rst, m_tvalid |-> (m_tdata[14:13] == STATUS_GOOD || m_tdata[14:13] == STATUS_BAD_START || m_tdata[14:13] == STATUS_BAD_SUM), "bad status code")

  `OPIR_ASSERT(a_bad_start_word, clk, rst, (m_tvalid && m_tdata[14:13] == STATUS_BAD_START) |-> (m_tlast && m_tdata[12:0] == 13'd0), "bad start word not single and zero")

  `OPIR_ASSERT(a_no_take_while_out_pending, clk, rst, (m_tvalid && !m_tlast) |-> !s_tready, "sample taken mid-packet")

endmodule

bind oversampled_ir_packet_receiver opir_checker u_opir_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
